[src/ring_block_allocator_assert.svh]
// Assertion macros used by the allocator's top level.
`ifndef RING_BLOCK_ALLOCATOR_ASSERT_SVH
`define RING_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RBA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// Next-cycle implication, checked outside reset.
`define RBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

[src/rba_pkg.sv]
package rba_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int IDX_W        = 6;
   localparam int LOG2_W       = 3;
   localparam int RING_LOG2_MAX = 6;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [LOG2_W-1:0] RING_LOG2_RESET = 3'd6;

   typedef struct packed {
      logic             mode;
      logic [IDX_W-1:0] free_index;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] block_index;
   } rsp_type;

   typedef struct packed {
      logic start_alloc;
      logic do_free;
      logic scan_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic scan_hit;
      logic scan_last;
   } dp_status_type;

   // Index mask of the ring: at least two blocks, at most the whole pool.
   function automatic logic [IDX_W-1:0] ring_mask(input logic [LOG2_W-1:0] lg);
      logic [LOG2_W-1:0] e;
      logic [IDX_W:0]    full;
      logic [IDX_W:0]    tmp;
      if (lg < LOG2_W'(1)) begin
         e = LOG2_W'(1);
      end else if (lg > LOG2_W'(RING_LOG2_MAX)) begin
         e = LOG2_W'(RING_LOG2_MAX);
      end else begin
         e = lg;
      end
      full = (IDX_W+1)'(1) << e;
      tmp = full - (IDX_W+1)'(1);
      return tmp[IDX_W-1:0];
   endfunction

endpackage

[src/rba_ctrl.sv]
module rba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rba_pkg::req_type       req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rba_pkg::dp_status_type dp_status,
   output rba_pkg::cmd_type       cmd
);
   import rba_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_PUSH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_word.mode == MODE_FREE) begin
                  cmd.do_free = 1'b1;
                  state_in = S_PUSH;
               end else begin
                  cmd.start_alloc = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (dp_status.scan_hit || dp_status.scan_last) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[src/rba_datapath.sv]
module rba_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [rba_pkg::LOG2_W-1:0]    csr_write_data,
   input  rba_pkg::req_type              req_word,
   input  rba_pkg::cmd_type              cmd,
   output rba_pkg::dp_status_type        dp_status,
   output rba_pkg::rsp_type              rsp_word
);
   import rba_pkg::*;

   logic [LOG2_W-1:0]     ring_log2_ff, ring_log2_in;
   logic [MAX_BLOCKS-1:0] used_ff, used_in;
   logic [IDX_W-1:0]      next_ff, next_in;
   logic [IDX_W-1:0]      scan_ff, scan_in;
   logic [IDX_W-1:0]      count_ff, count_in;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_ff, rsp_in;
   logic [IDX_W-1:0]      mask;
   logic [IDX_W-1:0]      step;
   logic                  cur_used;

   assign mask     = ring_mask(ring_log2_ff);
   assign cur_used = used_ff[scan_ff];
   assign step     = (scan_ff + IDX_W'(1)) & mask;
   assign dp_status.scan_hit  = !cur_used;
   assign dp_status.scan_last = (count_ff == mask);
   assign rsp_word = rsp_ff;

   always_comb begin
      ring_log2_in = ring_log2_ff;
      used_in      = used_ff;
      next_in      = next_ff;
      scan_in      = scan_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;

      if (csr_write_enable) begin
         ring_log2_in = csr_write_data;
      end

      if (cmd.start_alloc) begin
         // A shrunk ring may leave the rotating index outside; wrap it first.
         scan_in  = next_ff & mask;
         count_in = '0;
      end

      if (cmd.do_free) begin
         res_in.block_index = '0;
         if ((req_word.free_index & ~mask) == '0) begin
            used_in[req_word.free_index] = 1'b0;
            res_in.status = ST_OK;
         end else begin
            res_in.status = ST_RANGE;
         end
      end

      if (cmd.scan_step) begin
         priority if (!cur_used) begin
            used_in[scan_ff]   = 1'b1;
            next_in            = step;
            res_in.status      = ST_OK;
            res_in.block_index = scan_ff;
         end else if (count_ff == mask) begin
            // Whole ring inspected; the index is back where it started.
            next_in            = step;
            res_in.status      = ST_FULL;
            res_in.block_index = '0;
         end else begin
            scan_in  = step;
            count_in = count_ff + IDX_W'(1);
         end
      end

      if (cmd.load_rsp) begin
         rsp_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_log2_ff <= RING_LOG2_RESET;
         used_ff      <= '0;
         next_ff      <= '0;
      end else begin
         ring_log2_ff <= ring_log2_in;
         used_ff      <= used_in;
         next_ff      <= next_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      count_ff <= count_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

endmodule

[src/ring_block_allocator.sv]
// Channel   Direction  Handshake             Word
// req_      in         req_valid/req_stall   mode, free_index
// rsp_      out        rsp_valid/rsp_stall   status, block_index
// csr_      in         csr_write_enable      ring_size_log2
//
// A free goes from idle straight to the output stage. An allocation first scans
// the ring, one block per cycle, inspecting from 1 up to the ring size blocks.
// The result sits in an output register, so the next word is taken while it waits.
// Reset is synchronous; all in-use bits clear at once, with no clearing pass.
`include "ring_block_allocator_assert.svh"

module ring_block_allocator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  rba_pkg::req_type           req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rba_pkg::rsp_type           rsp_word,
   input  logic                       csr_write_enable,
   input  logic [rba_pkg::LOG2_W-1:0] csr_write_data
);
   import rba_pkg::*;

   cmd_type       cmd;
   dp_status_type dp_status;

   rba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   rba_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_word         (req_word),
      .cmd              (cmd),
      .dp_status        (dp_status),
      .rsp_word         (rsp_word)
   );

   `RBA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `RBA_ASSERT_NEXT(a_load_shows_result, clock, reset, cmd.load_rsp, rsp_valid)
   `RBA_ASSERT_IMPL(a_one_command, clock, reset, 1'b1, $onehot0(cmd))
   `RBA_ASSERT_IMPL(a_full_gives_zero, clock, reset, rsp_valid && rsp_word.status == ST_FULL, rsp_word.block_index == '0)

endmodule

[tb/ring_block_allocator_test.sv]
module ring_block_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rba_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 300;
   localparam int MAX_LINES      = 20;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_word = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_word;
   logic                csr_write_enable = 1'b0;
   logic [LOG2_W-1:0]   csr_write_data = '0;

   // Model of the pool as seen through the ports.
   logic                in_use [MAX_BLOCKS];
   logic [IDX_W-1:0]    scan_ptr;
   logic [LOG2_W-1:0]   span_log2;
   rsp_type             expected_rsps [$];

   int error_count = 0;
   int n_allocs = 0;
   int n_full = 0;
   int n_frees = 0;
   int n_range = 0;
   int n_settings = 0;

   bit gaps_on = 1'b1;
   bit stalls_on = 1'b1;
   int hold_request = 0;
   int stall_left = 0;

   ring_block_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   function automatic logic [IDX_W-1:0] span_mask(input logic [LOG2_W-1:0] lg);
      int e;
      e = (lg == '0) ? 1 : int'(lg);
      if (e > RING_LOG2_MAX) e = RING_LOG2_MAX;
      return IDX_W'((1 << e) - 1);
   endfunction

   // Applies one word to the pool model and returns the answer it must give.
   function automatic rsp_type pool_outcome(input req_type w);
      rsp_type          r;
      logic [IDX_W-1:0] m;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] cur;
      bit               found;
      m = span_mask(span_log2);
      r.status = ST_OK;
      r.block_index = '0;
      if (w.mode == MODE_ALLOC) begin
         n_allocs++;
         idx = scan_ptr & m;
         found = 1'b0;
         for (int k = 0; k <= int'(m); k++) begin
            cur = idx;
            idx = (idx + 1'b1) & m;
            if (!in_use[cur]) begin
               in_use[cur] = 1'b1;
               r.block_index = cur;
               found = 1'b1;
               break;
            end
         end
         // The pointer moves past every block looked at, the taken one included.
         scan_ptr = idx;
         if (!found) begin
            r.status = ST_FULL;
            n_full++;
         end
      end else begin
         n_frees++;
         if (w.free_index <= m) begin
            in_use[w.free_index] = 1'b0;
         end else begin
            r.status = ST_RANGE;
            n_range++;
         end
      end
      return r;
   endfunction

   function automatic int idle_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic int send_gap();
      if (!gaps_on || $urandom_range(0, 1) == 0) return 0;
      return idle_len();
   endfunction

   function automatic req_type make_word(input logic mode, input logic [IDX_W-1:0] idx);
      req_type w;
      w.mode = mode;
      w.free_index = idx;
      return w;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= MAX_LINES) begin
         $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      end
   endtask

   // Offers one word, holding it until taken; valid stays high when no gap follows.
   task automatic send_word(input req_type w, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      expected_rsps.push_back(pool_outcome(w));
   endtask

   task automatic alloc_one();
      send_word(make_word(MODE_ALLOC, IDX_W'($urandom_range(0, 63))), send_gap());
   endtask

   task automatic free_one(input logic [IDX_W-1:0] idx);
      send_word(make_word(MODE_FREE, idx), send_gap());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_ring_size(input logic [LOG2_W-1:0] lg);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= lg;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      span_log2 = lg;
      n_settings++;
   endtask

   // Receiver: random short and long stalls, plus a long hold on request.
   initial begin
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (hold_request > 0) begin
            rsp_stall <= 1'b1;
            stall_left = hold_request - 1;
            hold_request = 0;
         end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            stall_left = idle_len() - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("word with nothing pending, status", rsp_word.status, -1);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_word.status !== want.status)
               report_mismatch("status", rsp_word.status, want.status);
            if (rsp_word.block_index !== want.block_index)
               report_mismatch("block_index", rsp_word.block_index, want.block_index);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // Allocation order after reset, freeing a free block, next fit after a free.
   task automatic test_directed_basics();
      alloc_one();
      alloc_one();
      alloc_one();
      free_one(6'd1);
      alloc_one();
      free_one(6'd63);
      free_one(6'd0);
   endtask

   // Ring of two via a zero setting: pointer outside the ring, full ring,
   // frees outside the ring.
   task automatic test_small_ring();
      set_ring_size(3'd0);
      alloc_one();
      alloc_one();
      alloc_one();
      free_one(6'd2);
      free_one(6'd63);
      free_one(6'd1);
      alloc_one();
      alloc_one();
   endtask

   // A setting above the pool is capped at the whole pool; then the ring of two again.
   task automatic test_capped_ring();
      set_ring_size(3'd7);
      alloc_one();
      free_one(6'd62);
      alloc_one();
      set_ring_size(3'd1);
      alloc_one();
      free_one(6'd3);
      alloc_one();
   endtask

   task automatic run_phase(input logic [LOG2_W-1:0] lg, input int count, input int alloc_pct);
      logic [IDX_W-1:0] idx;
      set_ring_size(lg);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < alloc_pct) begin
            alloc_one();
         end else begin
            if ($urandom_range(0, 99) < 75)
               idx = IDX_W'($urandom_range(0, int'(span_mask(span_log2))));
            else
               idx = IDX_W'($urandom_range(0, 63));
            free_one(idx);
         end
      end
   endtask

   task automatic test_random_traffic();
      logic [LOG2_W-1:0] order [8] = '{3'd0, 3'd7, 3'd1, 3'd6, 3'd2, 3'd5, 3'd3, 3'd4};
      for (int p = 0; p < 12; p++) begin
         // One phase runs with no idling on either side.
         gaps_on = (p != 3) && ($urandom_range(0, 4) != 0);
         stalls_on = (p != 3) && ($urandom_range(0, 4) != 0);
         if (p < 8)
            run_phase(order[p], 50, $urandom_range(35, 85));
         else
            run_phase(LOG2_W'($urandom_range(0, 7)), 50, $urandom_range(35, 85));
      end
      gaps_on = 1'b1;
      stalls_on = 1'b1;
   endtask

   // The receiver holds off while words keep coming, so the input must stall.
   task automatic test_output_backpressure();
      set_ring_size(3'd3);
      hold_request = LONG_HOLD;
      for (int i = 0; i < 40; i++) begin
         if ($urandom_range(0, 1) == 0)
            send_word(make_word(MODE_ALLOC, '0), 0);
         else
            send_word(make_word(MODE_FREE, IDX_W'($urandom_range(0, 63))), 0);
      end
      wait_drained();
   endtask

   // The sender stops until every answer is back, then resumes.
   task automatic test_drain_pause();
      set_ring_size(3'd6);
      for (int i = 0; i < 20; i++) alloc_one();
      wait_drained();
      for (int i = 0; i < 20; i++) begin
         if (i % 2 == 0) alloc_one();
         else free_one(IDX_W'($urandom_range(0, 63)));
      end
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < MAX_BLOCKS; i++) in_use[i] = 1'b0;
      scan_ptr = '0;
      span_log2 = RING_LOG2_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_basics();
      test_small_ring();
      test_capped_ring();
      test_random_traffic();
      test_output_backpressure();
      test_drain_pause();

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Covered %0d allocations (%0d on a full ring) and %0d frees (%0d outside the ring)",
               n_allocs, n_full, n_frees, n_range);
      $display("across %0d ring size writes, with random gaps, stalls and a long output hold.",
               n_settings);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
